// File: hw/rtl/llh_pkg.sv
// Shared types and constants of the log-linear histogram engine.
`default_nettype none

package llh_pkg;

    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 64;
    localparam int Q_W      = 17;
    localparam int Q_FRAC   = 16;
    localparam int BUCKET_W = 10;
    localparam int VALUE_W  = 41;
    localparam int TOTAL_W  = 40;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Classified item handed from the front end to the execution side.
    typedef struct packed {
        t_op                 op;
        logic [BUCKET_W-1:0] bucket;
        logic [Q_W-1:0]      quantile;
    } t_cmd;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_REC,
        S_MUL,
        S_TGT,
        S_SCAN,
        S_EMIT,
        S_CLEAR
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/llh_front.sv
// Front end: accepts items and maps each sample to its bucket index.
`default_nettype none

module llh_front
    import llh_pkg::*;
#(
    parameter int SUB_BITS = 4,
    parameter int TOP_MSB  = 40,
    parameter int BUCKETS  = 608
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [Q_W-1:0]      i_quantile,
    input  wire logic                i_init,
    input  wire logic [QCNT_W-1:0]   i_q_count,
    output logic                     o_busy,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    localparam int GROUPS = 8;
    localparam int GRP_W  = 8;
    localparam int CW     = QCNT_W + 1;

    logic                           w_accept;
    logic [GROUPS-1:0]              w_nz;
    logic [GROUPS-1:0][2:0]         w_pos;

    logic                           r_valid;
    t_op                            r_op;
    logic [SAMPLE_W-1:0]            r_sample;
    logic [Q_W-1:0]                 r_quantile;
    logic [GROUPS-1:0]              r_nz;
    logic [GROUPS-1:0][2:0]         r_pos;

    logic [2:0]                     w_grp;
    logic [5:0]                     w_msb;
    logic [5:0]                     w_shamt;
    logic [SAMPLE_W-1:0]            w_shifted;
    logic [15:0]                    w_hi;
    logic [15:0]                    w_raw;

    // An item in the input register always finds room in the queue.
    assign o_busy   = i_init
                   || (({1'b0, i_q_count} + CW'(r_valid)) >= CW'(QDEPTH));
    assign w_accept = i_start && !o_busy;

    // First half of the leading-one search: one position per byte.
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_nz[g]  = |i_sample[g*GRP_W +: GRP_W];
            w_pos[g] = 3'd0;
            for (int b = 0; b < GRP_W; b++) begin
                if (i_sample[g*GRP_W + b]) begin
                    w_pos[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= t_op'(i_operation);
            r_sample   <= i_sample;
            r_quantile <= i_quantile;
            r_nz       <= w_nz;
            r_pos      <= w_pos;
        end
    end

    always_comb begin
        w_grp = 3'd0;
        for (int g = 0; g < GROUPS; g++) begin
            if (r_nz[g]) begin
                w_grp = 3'(g);
            end
        end
        w_msb     = {w_grp, r_pos[w_grp]};
        w_shamt   = w_msb - 6'(SUB_BITS);
        w_shifted = r_sample >> w_shamt;
        w_hi      = 16'(w_msb) - 16'(SUB_BITS) + 16'd1;
        w_raw     = (w_hi << SUB_BITS) | 16'(w_shifted[SUB_BITS-1:0]);
        if (r_sample[SAMPLE_W-1:SUB_BITS] == '0) begin
            w_raw = 16'(r_sample[SUB_BITS-1:0]);
        end else if (w_msb > 6'(TOP_MSB)) begin
            w_raw = 16'(BUCKETS - 1);
        end
        if (w_raw > 16'(BUCKETS - 1)) begin
            w_raw = 16'(BUCKETS - 1);
        end
    end

    assign o_push          = r_valid;
    assign o_cmd.op        = r_op;
    assign o_cmd.bucket    = BUCKET_W'(w_raw);
    assign o_cmd.quantile  = r_quantile;

endmodule

`default_nettype wire

// File: hw/rtl/llh_queue.sv
// Short command queue between the front end and the execution side.
`default_nettype none

module llh_queue
    import llh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_cmd              i_cmd,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output t_cmd                   o_cmd,
    output logic [QCNT_W-1:0]      o_count
);

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic                w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/llh_back.sv
// Execution side: count store, record update, percentile scan and clear sweep.
`default_nettype none

module llh_back
    import llh_pkg::*;
#(
    parameter int SUB_BITS    = 4,
    parameter int BUCKETS     = 608,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire t_cmd                i_cmd,
    output logic                     o_pop,
    output logic                     o_init,
    output logic                     o_strobe,
    output logic [BUCKET_W-1:0]      o_bucket,
    output logic [VALUE_W-1:0]       o_value,
    output logic                     o_empty_res
);

    localparam int IDX_W  = $clog2(BUCKETS);
    localparam int PROD_W = Q_W + TOTAL_W;
    localparam int TGT_W  = PROD_W + 1 - Q_FRAC;

    logic [COUNT_WIDTH-1:0] r_mem [BUCKETS];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic [Q_W-1:0]       r_q, n_q;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [TGT_W-1:0]     r_target, n_target;
    logic [63:0]          r_acc, n_acc;
    logic                 r_out_valid, n_out_valid;
    logic [IDX_W-1:0]     r_out_bucket, n_out_bucket;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;
    logic                 r_out_empty, n_out_empty;

    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [COUNT_WIDTH-1:0] w_wdata;
    logic [IDX_W-1:0]       w_raddr;
    logic [COUNT_WIDTH-1:0] w_cnt_inc;
    logic [TOTAL_W-1:0]     w_total_inc;
    logic [64:0]            w_sum;
    logic [63:0]            w_acc_new;
    logic                   w_hit;
    logic                   w_last;
    logic [PROD_W:0]        w_round;
    logic [VALUE_W-1:0]     w_mid;

    // Midpoint of a bucket; a shift that would overflow 64 bits gives all ones.
    function automatic logic [VALUE_W-1:0] f_midpoint(input logic [IDX_W-1:0] idx);
        logic [15:0] idx16;
        logic [15:0] shift16;
        logic [63:0] base;
        logic [63:0] v;
        idx16   = 16'(idx);
        shift16 = (idx16 >> SUB_BITS) - 16'd1;
        base    = 64'({1'b1, idx16[SUB_BITS-1:0]});
        if (idx16 < 16'(1 << SUB_BITS)) begin
            v = 64'(idx16);
        end else if (shift16 > 16'(63 - SUB_BITS)) begin
            v = '1;
        end else begin
            v = (base << shift16) + ((64'd1 << shift16) >> 1);
        end
        return v[VALUE_W-1:0];
    endfunction

    assign w_cnt_inc   = (r_rd_data == '1) ? r_rd_data : r_rd_data + COUNT_WIDTH'(1);
    assign w_total_inc = (r_total == '1) ? r_total : r_total + TOTAL_W'(1);
    assign w_sum       = {1'b0, r_acc} + 65'(r_rd_data);
    assign w_acc_new   = w_sum[64] ? '1 : w_sum[63:0];
    assign w_hit       = (w_acc_new >= 64'(r_target)) && (r_rd_data != '0);
    assign w_last      = (r_addr == IDX_W'(BUCKETS - 1));
    assign w_round     = {1'b0, r_prod} + (PROD_W+1)'((1 << Q_FRAC) - 1);
    assign w_mid       = f_midpoint(r_addr);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q          <= n_q;
        r_prod       <= n_prod;
        r_target     <= n_target;
        r_acc        <= n_acc;
        r_out_bucket <= n_out_bucket;
        r_out_value  <= n_out_value;
        r_out_empty  <= n_out_empty;
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_total      = r_total;
        n_q          = r_q;
        n_prod       = r_prod;
        n_target     = r_target;
        n_acc        = r_acc;
        n_out_valid  = 1'b0;
        n_out_bucket = r_out_bucket;
        n_out_value  = r_out_value;
        n_out_empty  = r_out_empty;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = '0;
        w_raddr      = r_addr;
        o_pop        = 1'b0;

        case (r_state)
            S_INIT, S_CLEAR: begin
                w_we = 1'b1;
                if (w_last) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                    if (r_state == S_CLEAR) begin
                        n_out_valid  = 1'b1;
                        n_out_bucket = '0;
                        n_out_value  = '0;
                        n_out_empty  = 1'b0;
                    end
                end else begin
                    n_addr = r_addr + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_RECORD: begin
                            w_raddr = i_cmd.bucket[IDX_W-1:0];
                            n_addr  = i_cmd.bucket[IDX_W-1:0];
                            n_state = S_REC;
                        end
                        OP_QUERY: begin
                            if (r_total == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_bucket = '0;
                                n_out_value  = '0;
                                n_out_empty  = 1'b1;
                            end else begin
                                n_q     = i_cmd.quantile;
                                n_state = S_MUL;
                            end
                        end
                        OP_CLEAR: begin
                            n_addr  = '0;
                            n_total = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_bucket = '0;
                            n_out_value  = '0;
                            n_out_empty  = 1'b0;
                        end
                    endcase
                end
            end
            S_REC: begin
                w_we         = 1'b1;
                w_wdata      = w_cnt_inc;
                n_total      = w_total_inc;
                n_out_valid  = 1'b1;
                n_out_bucket = r_addr;
                n_out_value  = w_mid;
                n_out_empty  = 1'b0;
                n_state      = S_IDLE;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_q) * PROD_W'(r_total);
                n_state = S_TGT;
            end
            S_TGT: begin
                n_target = TGT_W'(w_round >> Q_FRAC);
                n_acc    = '0;
                n_addr   = '0;
                w_raddr  = '0;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                // The read data always belongs to r_addr; the last bucket is the fallback.
                n_acc = w_acc_new;
                if (w_hit || w_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_addr  = r_addr + IDX_W'(1);
                    w_raddr = r_addr + IDX_W'(1);
                end
            end
            S_EMIT: begin
                n_out_valid  = 1'b1;
                n_out_bucket = r_addr;
                n_out_value  = w_mid;
                n_out_empty  = 1'b0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_init      = (r_state == S_INIT);
    assign o_strobe    = r_out_valid;
    assign o_bucket    = BUCKET_W'(r_out_bucket);
    assign o_value     = r_out_value;
    assign o_empty_res = r_out_empty;

endmodule

`default_nettype wire

// File: hw/rtl/log_linear_histogram_percentile.sv
// Top level of the log-linear histogram engine with percentile queries.
//
// An item (operation, sample, quantile) is taken at a clock edge where start is
// high and busy is low. Every item yields exactly one result, shown on o_bucket,
// o_value and o_empty_res for one cycle while o_strobe is high; the receiver
// cannot hold it off, so results are never delayed by the output side.
// The front end registers the item, finds the sample's bucket from that
// register and drops it into a four-entry queue; busy rises when the queue and
// the front register together are full.
// The execution side works on one item at a time. A record is a read and a
// write of one counter in the store. A percentile query does the multiply
// (S_MUL) and the target rounding (S_TGT), then reads one bucket per cycle up
// to the one found (at most BUCKETS reads) and reports from S_EMIT; on an empty
// histogram it reports the empty flag without a scan. A clear writes one bucket
// per cycle over all BUCKETS buckets, then reports.
// After reset the store is swept to zero with busy held high.
`default_nettype none

module log_linear_histogram_percentile
    import llh_pkg::*;
#(
    parameter int SUB_BITS    = 4,
    parameter int TOP_MSB     = 40,
    parameter int BUCKETS     = 608,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_operation,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [Q_W-1:0]      i_quantile,
    output logic                     o_strobe,
    output logic [BUCKET_W-1:0]      o_bucket,
    output logic [VALUE_W-1:0]       o_value,
    output logic                     o_empty_res
);

    logic               w_init;
    logic               w_push;
    t_cmd               w_push_cmd;
    logic               w_q_valid;
    t_cmd               w_q_cmd;
    logic [QCNT_W-1:0]  w_q_count;
    logic               w_pop;

    llh_front #(
        .SUB_BITS (SUB_BITS),
        .TOP_MSB  (TOP_MSB),
        .BUCKETS  (BUCKETS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_sample    (i_sample),
        .i_quantile  (i_quantile),
        .i_init      (w_init),
        .i_q_count   (w_q_count),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    llh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .o_count (w_q_count)
    );

    llh_back #(
        .SUB_BITS    (SUB_BITS),
        .BUCKETS     (BUCKETS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_init      (w_init),
        .o_strobe    (o_strobe),
        .o_bucket    (o_bucket),
        .o_value     (o_value),
        .o_empty_res (o_empty_res)
    );

endmodule

`default_nettype wire
